>>> rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL files.
// All checks use clk_i and are off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/frmt_pkg.sv
// ----------------------------------------------------------------------------
// frmt_pkg
// Shared types, sizes and codes of the first-match rule table.
// ----------------------------------------------------------------------------
package frmt_pkg;

  localparam int RULES = 16;
  localparam int IDX_W = (RULES > 1) ? $clog2(RULES) : 1;
  localparam int CNT_W = $clog2(RULES + 1);

  // request kinds
  localparam logic [1:0] ACT_ADD    = 2'd0;
  localparam logic [1:0] ACT_DELETE = 2'd1;
  localparam logic [1:0] ACT_CHECK  = 2'd2;

  // result codes
  localparam logic [2:0] ST_ADDED    = 3'd0;
  localparam logic [2:0] ST_INVALID  = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_DELETED  = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;
  localparam logic [2:0] ST_ACCEPTED = 3'd5;
  localparam logic [2:0] ST_REJECTED = 3'd6;

  // entry flag bits
  localparam int FL_ALLOW = 0;
  localparam int FL_IPR   = 1;
  localparam int FL_PORTR = 2;

  typedef struct packed {
    logic [31:0] ip_lo;
    logic [31:0] ip_hi;
    logic [15:0] pt_lo;
    logic [15:0] pt_hi;
    logic [2:0]  flags;
  } entry_t;

  // held request, high ends already normalized for single values
  typedef struct packed {
    logic [1:0]  action;
    logic        allow;
    logic [31:0] ip_lo;
    logic [31:0] ip_hi;
    logic        ip_r;
    logic [15:0] pt_lo;
    logic [15:0] pt_hi;
    logic        pt_r;
    logic [31:0] probe_ip;
    logic [15:0] probe_port;
  } req_t;

  // search token walking down the cell row
  typedef struct packed {
    logic             vld;
    logic             found;
    logic             allow;
    logic [IDX_W-1:0] hit;
  } tok_t;

endpackage

>>> rtl/core/frmt_cell.sv
// ----------------------------------------------------------------------------
// frmt_cell
// One table entry with its compare logic and a stage of the search token.
// ----------------------------------------------------------------------------
module frmt_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [frmt_pkg::IDX_W-1:0]   idx_i,
  input  logic                         active_i,
  input  frmt_pkg::req_t               req_i,
  input  frmt_pkg::tok_t               tok_i,
  output frmt_pkg::tok_t               tok_o,
  input  logic                         load_i,
  input  frmt_pkg::entry_t             wr_entry_i,
  input  logic                         shift_i,
  input  frmt_pkg::entry_t             next_i,
  output frmt_pkg::entry_t             entry_o
);

  frmt_pkg::entry_t entry_q;
  frmt_pkg::tok_t   tok_q, tok_d;
  logic             hit_chk, hit_del, match;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      entry_q <= wr_entry_i;
    end else if (shift_i) begin
      entry_q <= next_i;
    end
  end

  assign hit_chk = (req_i.probe_ip >= entry_q.ip_lo) && (req_i.probe_ip <= entry_q.ip_hi) &&
                   (req_i.probe_port >= entry_q.pt_lo) &&
                   (req_i.probe_port <= entry_q.pt_hi);

  // allow mark is not part of the delete key
  assign hit_del = (req_i.ip_lo == entry_q.ip_lo) && (req_i.ip_hi == entry_q.ip_hi) &&
                   (req_i.pt_lo == entry_q.pt_lo) && (req_i.pt_hi == entry_q.pt_hi) &&
                   (entry_q.flags[frmt_pkg::FL_IPR] == req_i.ip_r) &&
                   (entry_q.flags[frmt_pkg::FL_PORTR] == req_i.pt_r);

  always_comb begin
    case (req_i.action)
      frmt_pkg::ACT_DELETE: match = active_i & hit_del;
      frmt_pkg::ACT_CHECK:  match = active_i & hit_chk;
      default:              match = 1'b0;
    endcase
  end

  always_comb begin
    tok_d = tok_i;
    if (!tok_i.found && match) begin
      tok_d.found = 1'b1;
      tok_d.hit   = idx_i;
      tok_d.allow = entry_q.flags[frmt_pkg::FL_ALLOW];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o   = tok_q;
  assign entry_o = entry_q;

endmodule

>>> rtl/core/firewall_rule_match_table.sv
// ----------------------------------------------------------------------------
// firewall_rule_match_table
// Ordered first-match access-control table built as a row of entry cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one request: add, delete
//   or check. Output channel (out_valid_o / out_stall_i) returns one status
//   and hit index per request, in request order.
//   A check or delete sends a search token down the row of RULES cells, one
//   cell per cycle; the first matching cell marks the token. Its result is
//   registered when the token leaves the row, then loaded into the output
//   register; the next request is taken only after that. An add or an
//   unknown request needs no search and goes straight to the result step;
//   the next request again waits until its result is loaded.
//   A delete shifts every later entry up one cell at once.
//   Reset clears the entry count and the control state; entry contents are
//   left as they are and are never read before being written.
//   The output register holds a result while out_stall_i is high; a new
//   request is still taken meanwhile and waits in its final step until the
//   output register frees up.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module firewall_rule_match_table (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  action_i,
  input  logic        allow_i,
  input  logic [31:0] rule_ip_low_i,
  input  logic [31:0] rule_ip_high_i,
  input  logic        ip_ranged_i,
  input  logic [15:0] rule_port_low_i,
  input  logic [15:0] rule_port_high_i,
  input  logic        port_ranged_i,
  input  logic [31:0] probe_ip_i,
  input  logic [15:0] probe_port_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [3:0]  hit_index_o
);

  localparam int RULES = frmt_pkg::RULES;
  localparam int IDX_W = frmt_pkg::IDX_W;
  localparam int CNT_W = frmt_pkg::CNT_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_RESP = 2'd2;

  logic [1:0]       state_q, state_d;
  frmt_pkg::req_t   req_q;
  logic [CNT_W-1:0] cnt_q;
  frmt_pkg::tok_t   tok_src_q;
  logic             res_found_q, res_allow_q;
  logic [IDX_W-1:0] res_hit_q;
  logic             out_valid_q;
  logic [2:0]       status_q;
  logic [3:0]       hit_q;

  frmt_pkg::tok_t   tok [RULES+1];
  frmt_pkg::entry_t ent [RULES];
  logic [RULES-1:0] active, load, shift, tok_vld;

  logic             in_acc, commit, out_free;
  logic             add_bad, add_full, add_ok, del_ok;
  logic [2:0]       status_d;
  logic [IDX_W-1:0] hit_sel;
  logic [IDX_W+3:0] hit_ext;
  frmt_pkg::entry_t wr_entry;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign out_free   = ~out_valid_q | ~out_stall_i;
  assign commit     = (state_q == S_RESP) & out_free;

  // request register, single values expanded to ranges
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q.action     <= action_i;
      req_q.allow      <= allow_i;
      req_q.ip_lo      <= rule_ip_low_i;
      req_q.ip_hi      <= ip_ranged_i ? rule_ip_high_i : rule_ip_low_i;
      req_q.ip_r       <= ip_ranged_i;
      req_q.pt_lo      <= rule_port_low_i;
      req_q.pt_hi      <= port_ranged_i ? rule_port_high_i : rule_port_low_i;
      req_q.pt_r       <= port_ranged_i;
      req_q.probe_ip   <= probe_ip_i;
      req_q.probe_port <= probe_port_i;
    end
  end

  // token enters cell 0 the cycle after a delete or check is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_src_q <= '0;
    end else begin
      tok_src_q.vld   <= in_acc && (action_i == frmt_pkg::ACT_DELETE ||
                                    action_i == frmt_pkg::ACT_CHECK);
      tok_src_q.found <= 1'b0;
      tok_src_q.allow <= 1'b0;
      tok_src_q.hit   <= '0;
    end
  end

  assign tok[0] = tok_src_q;

  // entry written by an add
  always_comb begin
    wr_entry.ip_lo = req_q.ip_lo;
    wr_entry.ip_hi = req_q.ip_hi;
    wr_entry.pt_lo = req_q.pt_lo;
    wr_entry.pt_hi = req_q.pt_hi;
    wr_entry.flags = '0;
    wr_entry.flags[frmt_pkg::FL_ALLOW] = req_q.allow;
    wr_entry.flags[frmt_pkg::FL_IPR]   = req_q.ip_r;
    wr_entry.flags[frmt_pkg::FL_PORTR] = req_q.pt_r;
  end

  assign add_bad  = (req_q.pt_lo == 16'd0) || (req_q.pt_hi == 16'd0) ||
                    (req_q.pt_hi < req_q.pt_lo);
  assign add_full = (cnt_q == CNT_W'(RULES));
  assign add_ok   = commit && (req_q.action == frmt_pkg::ACT_ADD) && !add_bad && !add_full;
  assign del_ok   = commit && (req_q.action == frmt_pkg::ACT_DELETE) && res_found_q;

  for (genvar g = 0; g < RULES; g++) begin : g_cell
    assign active[g]  = (CNT_W'(g) < cnt_q);
    assign load[g]    = add_ok && (cnt_q[IDX_W-1:0] == IDX_W'(g));
    assign shift[g]   = del_ok && (IDX_W'(g) >= res_hit_q);
    assign tok_vld[g] = tok[g+1].vld;

    frmt_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .idx_i      (IDX_W'(g)),
      .active_i   (active[g]),
      .req_i      (req_q),
      .tok_i      (tok[g]),
      .tok_o      (tok[g+1]),
      .load_i     (load[g]),
      .wr_entry_i (wr_entry),
      .shift_i    (shift[g]),
      .next_i     ((g == RULES - 1) ? ent[g] : ent[(g == RULES - 1) ? g : g + 1]),
      .entry_o    (ent[g])
    );
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (action_i == frmt_pkg::ACT_DELETE || action_i == frmt_pkg::ACT_CHECK) begin
            state_d = S_SCAN;
          end else begin
            state_d = S_RESP;
          end
        end
      end
      S_SCAN: begin
        if (tok[RULES].vld) begin
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // result decode
  always_comb begin
    status_d = frmt_pkg::ST_REJECTED;
    hit_sel  = '0;
    unique case (req_q.action)
      frmt_pkg::ACT_ADD: begin
        if (add_bad) begin
          status_d = frmt_pkg::ST_INVALID;
        end else if (add_full) begin
          status_d = frmt_pkg::ST_FULL;
        end else begin
          status_d = frmt_pkg::ST_ADDED;
        end
      end
      frmt_pkg::ACT_DELETE: begin
        status_d = res_found_q ? frmt_pkg::ST_DELETED : frmt_pkg::ST_NOTFOUND;
        hit_sel  = res_found_q ? res_hit_q : '0;
      end
      frmt_pkg::ACT_CHECK: begin
        if (res_found_q && res_allow_q) begin
          status_d = frmt_pkg::ST_ACCEPTED;
        end
        hit_sel = res_found_q ? res_hit_q : '0;
      end
      default: status_d = frmt_pkg::ST_REJECTED;
    endcase
  end

  assign hit_ext = {4'b0, hit_sel};

  always_ff @(posedge clk_i) begin
    if (state_q == S_SCAN && tok[RULES].vld) begin
      res_found_q <= tok[RULES].found;
      res_allow_q <= tok[RULES].allow;
      res_hit_q   <= tok[RULES].hit;
    end
    if (commit) begin
      status_q <= status_d;
      hit_q    <= hit_ext[3:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (add_ok) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (del_ok) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign hit_index_o = hit_q;

  // checks
  `ASSERT_IMP(a_cnt_range, 1'b1, cnt_q <= CNT_W'(RULES), "entry count above table size")
  `ASSERT_IMP(a_tok_single, 1'b1, $onehot0(tok_vld), "more than one search token in row")
  `ASSERT_IMP(a_tok_scan, tok[RULES].vld, state_q == S_SCAN, "token left row outside scan")
  `ASSERT_NXT(a_acc_busy, in_acc, state_q != S_IDLE, "taken request left block idle")

endmodule

>>> bench/rule_table_checker.sv
// ----------------------------------------------------------------------------
// rule_table_checker
// Watches both channels of the rule table, predicts each status and hit index
// from its own copy of the table, and counts every mismatch.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rule_table_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [1:0]  action_i,
  input  logic        allow_i,
  input  logic [31:0] rule_ip_low_i,
  input  logic [31:0] rule_ip_high_i,
  input  logic        ip_ranged_i,
  input  logic [15:0] rule_port_low_i,
  input  logic [15:0] rule_port_high_i,
  input  logic        port_ranged_i,
  input  logic [31:0] probe_ip_i,
  input  logic [15:0] probe_port_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [2:0]  status_i,
  input  logic [3:0]  hit_index_i,
  output int          fail_count_o,
  output int          pending_o
);

  localparam int PRINT_CAP = 100;

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] hit;
  } decision_t;

  frmt_pkg::entry_t rule_row [frmt_pkg::RULES];
  int               rule_count;
  decision_t        decisions_q[$];
  int               result_num;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    rule_count   = 0;
    result_num   = 0;
  end

  task automatic report_mismatch(input string what);
    if (fail_count_o < PRINT_CAP) begin
      $display("[%0t] rule table result %0d: %s", $realtime, result_num, what);
    end
    fail_count_o++;
  endtask

  // Applies one request to the shadow table and returns its decision.
  task automatic decide_request(
    input  logic [1:0]  act,
    input  logic        allow,
    input  logic [31:0] ip_lo,
    input  logic [31:0] ip_hi_raw,
    input  logic        ip_r,
    input  logic [15:0] pt_lo,
    input  logic [15:0] pt_hi_raw,
    input  logic        pt_r,
    input  logic [31:0] pip,
    input  logic [15:0] ppt,
    output decision_t   dec
  );
    logic [31:0] ip_hi;
    logic [15:0] pt_hi;
    logic        done;
    int          i;
    int          j;
    ip_hi      = ip_r ? ip_hi_raw : ip_lo;
    pt_hi      = pt_r ? pt_hi_raw : pt_lo;
    dec.status = frmt_pkg::ST_REJECTED;
    dec.hit    = '0;
    done       = 1'b0;
    case (act)
      frmt_pkg::ACT_ADD: begin
        if (pt_lo == 16'd0 || pt_hi == 16'd0 || pt_hi < pt_lo) begin
          dec.status = frmt_pkg::ST_INVALID;
        end else if (rule_count >= frmt_pkg::RULES) begin
          dec.status = frmt_pkg::ST_FULL;
        end else begin
          rule_row[rule_count].ip_lo                     = ip_lo;
          rule_row[rule_count].ip_hi                     = ip_hi;
          rule_row[rule_count].pt_lo                     = pt_lo;
          rule_row[rule_count].pt_hi                     = pt_hi;
          rule_row[rule_count].flags                     = '0;
          rule_row[rule_count].flags[frmt_pkg::FL_ALLOW] = allow;
          rule_row[rule_count].flags[frmt_pkg::FL_IPR]   = ip_r;
          rule_row[rule_count].flags[frmt_pkg::FL_PORTR] = pt_r;
          rule_count++;
          dec.status = frmt_pkg::ST_ADDED;
        end
      end
      frmt_pkg::ACT_DELETE: begin
        // allow mark is not part of the compare
        dec.status = frmt_pkg::ST_NOTFOUND;
        for (i = 0; i < rule_count; i++) begin
          if (!done && rule_row[i].ip_lo == ip_lo && rule_row[i].ip_hi == ip_hi &&
              rule_row[i].pt_lo == pt_lo && rule_row[i].pt_hi == pt_hi &&
              rule_row[i].flags[frmt_pkg::FL_IPR] == ip_r &&
              rule_row[i].flags[frmt_pkg::FL_PORTR] == pt_r) begin
            for (j = i; j + 1 < rule_count; j++) rule_row[j] = rule_row[j + 1];
            rule_count--;
            dec.status = frmt_pkg::ST_DELETED;
            dec.hit    = i[3:0];
            done       = 1'b1;
          end
        end
      end
      frmt_pkg::ACT_CHECK: begin
        for (i = 0; i < rule_count; i++) begin
          if (!done && pip >= rule_row[i].ip_lo && pip <= rule_row[i].ip_hi &&
              ppt >= rule_row[i].pt_lo && ppt <= rule_row[i].pt_hi) begin
            dec.status = rule_row[i].flags[frmt_pkg::FL_ALLOW] ? frmt_pkg::ST_ACCEPTED :
                                                                 frmt_pkg::ST_REJECTED;
            dec.hit    = i[3:0];
            done       = 1'b1;
          end
        end
      end
      default: begin
        dec.status = frmt_pkg::ST_REJECTED;
      end
    endcase
  endtask

  always @(posedge clk_i) begin : watch
    decision_t want;
    decision_t got;
    if (rst_ni) begin
      // results first: a request taken at this edge cannot answer at it
      if (out_valid_i !== 1'b0 && out_stall_i === 1'b0) begin
        result_num++;
        got.status = status_i;
        got.hit    = hit_index_i;
        if (decisions_q.size() == 0) begin
          report_mismatch("result with no request outstanding");
        end else begin
          want = decisions_q.pop_front();
          if (got.status !== want.status) begin
            report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
          end
          if (got.hit !== want.hit) begin
            report_mismatch($sformatf("hit_index %0d, expected %0d", got.hit, want.hit));
          end
        end
      end
      if (in_valid_i === 1'b1 && in_stall_i === 1'b0) begin
        decide_request(action_i, allow_i, rule_ip_low_i, rule_ip_high_i, ip_ranged_i,
                       rule_port_low_i, rule_port_high_i, port_ranged_i,
                       probe_ip_i, probe_port_i, want);
        decisions_q.push_back(want);
      end
      pending_o <= decisions_q.size();
    end
  end

endmodule

>>> bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the first-match rule table: a directed opening, then random
// add/delete/check traffic, with some unknown requests, under several idle and stall patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  // request kind the block does not know; it must answer rejected, index 0
  localparam logic [1:0] ACT_UNKNOWN = 2'd3;

  localparam int RANDOM_PER_PHASE = 150;
  localparam int HOLDOFF_CYCLES   = 200;
  // no accept for this long means the block hung; well above the hold-off
  localparam int IDLE_LIMIT       = 3000;
  // drain time at the end: a check walks the whole cell row
  localparam int TAIL_CYCLES      = 2 * frmt_pkg::RULES + 8;

  logic        clk_i            = 1'b0;
  logic        rst_ni           = 1'b0;
  logic        in_valid_i       = 1'b0;
  logic        in_stall_o;
  logic [1:0]  action_i         = frmt_pkg::ACT_CHECK;
  logic        allow_i          = 1'b0;
  logic [31:0] rule_ip_low_i    = '0;
  logic [31:0] rule_ip_high_i   = '0;
  logic        ip_ranged_i      = 1'b0;
  logic [15:0] rule_port_low_i  = '0;
  logic [15:0] rule_port_high_i = '0;
  logic        port_ranged_i    = 1'b0;
  logic [31:0] probe_ip_i       = '0;
  logic [15:0] probe_port_i     = '0;
  logic        out_valid_o;
  logic        out_stall_i      = 1'b0;
  logic [2:0]  status_o;
  logic [3:0]  hit_index_o;

  int fail_count;
  int pending;

  // traffic shaping, changed per phase
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int add_pct       = 40;
  int delete_pct    = 20;
  int holdoff_seq   = 0;

  // rules offered lately; deletes and checks aim at them
  frmt_pkg::req_t recent_rules[$];
  logic [31:0] ip_pool   [4] = '{32'h0A000000, 32'hC0A80100, 32'h7FFFFF00, 32'hFFFFFF00};
  logic [15:0] port_pool [4] = '{16'd22, 16'd80, 16'd443, 16'd65500};

  firewall_rule_match_table dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .action_i         (action_i),
    .allow_i          (allow_i),
    .rule_ip_low_i    (rule_ip_low_i),
    .rule_ip_high_i   (rule_ip_high_i),
    .ip_ranged_i      (ip_ranged_i),
    .rule_port_low_i  (rule_port_low_i),
    .rule_port_high_i (rule_port_high_i),
    .port_ranged_i    (port_ranged_i),
    .probe_ip_i       (probe_ip_i),
    .probe_port_i     (probe_port_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .hit_index_o      (hit_index_o)
  );

  rule_table_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .action_i         (action_i),
    .allow_i          (allow_i),
    .rule_ip_low_i    (rule_ip_low_i),
    .rule_ip_high_i   (rule_ip_high_i),
    .ip_ranged_i      (ip_ranged_i),
    .rule_port_low_i  (rule_port_low_i),
    .rule_port_high_i (rule_port_high_i),
    .port_ranged_i    (port_ranged_i),
    .probe_ip_i       (probe_ip_i),
    .probe_port_i     (probe_port_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_i         (status_o),
    .hit_index_i      (hit_index_o),
    .fail_count_o     (fail_count),
    .pending_o        (pending)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Receiver: random stalls, plus a long hold-off whenever the sender asks.
  // The hold-off is counted here so the sender keeps pushing meanwhile.
  initial begin : receiver
    int holdoff_seen;
    holdoff_seen = 0;
    forever begin
      @(posedge clk_i);
      if (holdoff_seq != holdoff_seen) begin
        holdoff_seen = holdoff_seq;
        out_stall_i <= 1'b1;
        repeat (HOLDOFF_CYCLES) @(posedge clk_i);
      end
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // Watchdog: only cycles with no handshake on either side count.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= IDLE_LIMIT) begin
        $display("watchdog: no request moved for %0d cycles", IDLE_LIMIT);
        $display("** firewall_rule_match_table: FAILED **");
        $finish;
      end
    end
  end

  function automatic frmt_pkg::req_t fill_request(
    input logic [1:0]  act,
    input logic        allow,
    input logic [31:0] ip_lo,
    input logic [31:0] ip_hi,
    input logic        ip_r,
    input logic [15:0] pt_lo,
    input logic [15:0] pt_hi,
    input logic        pt_r,
    input logic [31:0] pip,
    input logic [15:0] ppt
  );
    frmt_pkg::req_t r;
    r.action     = act;
    r.allow      = allow;
    r.ip_lo      = ip_lo;
    r.ip_hi      = ip_hi;
    r.ip_r       = ip_r;
    r.pt_lo      = pt_lo;
    r.pt_hi      = pt_hi;
    r.pt_r       = pt_r;
    r.probe_ip   = pip;
    r.probe_port = ppt;
    return r;
  endfunction

  // Addresses cluster around a few bases so rules overlap and order matters.
  function automatic logic [31:0] pick_ip();
    logic [31:0] ip;
    case ($urandom_range(9))
      0:       ip = 32'h00000000;
      1:       ip = 32'hFFFFFFFF;
      2, 3, 4: ip = $urandom;
      default: ip = ip_pool[$urandom_range(3)] + $urandom_range(0, 255);
    endcase
    return ip;
  endfunction

  function automatic logic [15:0] pick_port();
    logic [15:0] pt;
    case ($urandom_range(9))
      0:       pt = 16'd1;
      1:       pt = 16'd65535;
      2, 3:    pt = 16'($urandom_range(1, 65535));
      default: pt = 16'(port_pool[$urandom_range(3)] + $urandom_range(0, 8));
    endcase
    return pt;
  endfunction

  function automatic frmt_pkg::req_t random_add();
    frmt_pkg::req_t r;
    r = fill_request(frmt_pkg::ACT_ADD, 1'($urandom), pick_ip(), $urandom, 1'($urandom),
                     pick_port(), 16'($urandom), 1'($urandom), $urandom, 16'($urandom));
    if (r.ip_r) begin
      case ($urandom_range(9))
        0, 1:    r.ip_hi = $urandom;                          // may be reversed
        2:       r.ip_hi = r.ip_lo - $urandom_range(1, 16);   // reversed
        default: r.ip_hi = r.ip_lo + $urandom_range(0, 64);
      endcase
    end
    if (r.pt_r) r.pt_hi = 16'(r.pt_lo + $urandom_range(0, 300));
    // a share of malformed port specs
    case ($urandom_range(19))
      0: r.pt_lo = 16'd0;
      1: begin
        r.pt_r  = 1'b1;
        r.pt_hi = 16'd0;
      end
      2: begin
        r.pt_r  = 1'b1;
        r.pt_lo = 16'($urandom_range(2, 65535));
        r.pt_hi = 16'(r.pt_lo - $urandom_range(1, r.pt_lo - 1));
      end
      default: ;
    endcase
    recent_rules.push_back(r);
    if (recent_rules.size() > 24) void'(recent_rules.pop_front());
    return r;
  endfunction

  function automatic frmt_pkg::req_t random_delete();
    frmt_pkg::req_t r;
    int             idx;
    if (recent_rules.size() == 0 || $urandom_range(3) == 0) begin
      r = random_add();
      void'(recent_rules.pop_back());
    end else begin
      idx = $urandom_range(recent_rules.size() - 1);
      r   = recent_rules[idx];
      // sometimes kept so a later delete of the same rule finds a duplicate or nothing
      if ($urandom_range(3) != 0) recent_rules.delete(idx);
      // unused high ends and the allow mark must not matter
      r.allow = 1'($urandom);
      if (!r.ip_r) r.ip_hi = $urandom;
      if (!r.pt_r) r.pt_hi = 16'($urandom);
    end
    r.action     = frmt_pkg::ACT_DELETE;
    r.probe_ip   = $urandom;
    r.probe_port = 16'($urandom);
    return r;
  endfunction

  function automatic frmt_pkg::req_t random_check();
    frmt_pkg::req_t r;
    frmt_pkg::req_t target;
    logic [31:0]    hi_ip;
    logic [15:0]    hi_pt;
    r = fill_request(frmt_pkg::ACT_CHECK, 1'($urandom), $urandom, $urandom, 1'($urandom),
                     16'($urandom), 16'($urandom), 1'($urandom), pick_ip(), pick_port());
    if (recent_rules.size() != 0 && $urandom_range(99) < 70) begin
      target = recent_rules[$urandom_range(recent_rules.size() - 1)];
      hi_ip  = target.ip_r ? target.ip_hi : target.ip_lo;
      hi_pt  = target.pt_r ? target.pt_hi : target.pt_lo;
      case ($urandom_range(5))
        0:       r.probe_ip = target.ip_lo - 32'd1;
        1:       r.probe_ip = hi_ip + 32'd1;
        2:       r.probe_ip = hi_ip;
        default: r.probe_ip = target.ip_lo + $urandom_range(0, 2);
      endcase
      case ($urandom_range(5))
        0:       r.probe_port = target.pt_lo - 16'd1;
        1:       r.probe_port = hi_pt + 16'd1;
        2:       r.probe_port = hi_pt;
        default: r.probe_port = target.pt_lo;
      endcase
    end
    return r;
  endfunction

  function automatic frmt_pkg::req_t random_request();
    int roll;
    roll = $urandom_range(99);
    if (roll < add_pct) return random_add();
    if (roll < add_pct + delete_pct) return random_delete();
    if (roll < 96) return random_check();
    return fill_request(ACT_UNKNOWN, 1'($urandom), $urandom, $urandom, 1'($urandom),
                        16'($urandom), 16'($urandom), 1'($urandom), $urandom, 16'($urandom));
  endfunction

  // Offers one request and returns at the edge where it is taken.
  task automatic send_request(input frmt_pkg::req_t r);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    action_i         <= r.action;
    allow_i          <= r.allow;
    rule_ip_low_i    <= r.ip_lo;
    rule_ip_high_i   <= r.ip_hi;
    ip_ranged_i      <= r.ip_r;
    rule_port_low_i  <= r.pt_lo;
    rule_port_high_i <= r.pt_hi;
    port_ranged_i    <= r.pt_r;
    probe_ip_i       <= r.probe_ip;
    probe_port_i     <= r.probe_port;
    in_valid_i       <= 1'b1;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
  endtask

  // Sender stays quiet until every outstanding request has answered.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin : stimulus
    int phase;
    int k;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- directed opening, no idling ---
    // check on an empty table, then an unknown request with every bit set
    send_request(fill_request(frmt_pkg::ACT_CHECK, 1'b1, '0, '0, 1'b0, 16'd0, 16'd0, 1'b0,
                              32'h0A000001, 16'd80));
    send_request(fill_request(ACT_UNKNOWN, 1'b1, '1, '1, 1'b1, '1, '1, 1'b1, '1, '1));
    // malformed port specs: zero low port, zero high port, reversed ports
    send_request(fill_request(frmt_pkg::ACT_ADD, 1'b1, 32'h01020304, '0, 1'b0, 16'd0, 16'd9,
                              1'b0, '0, '0));
    send_request(fill_request(frmt_pkg::ACT_ADD, 1'b1, 32'h01020304, '0, 1'b0, 16'd10, 16'd0,
                              1'b1, '0, '0));
    send_request(fill_request(frmt_pkg::ACT_ADD, 1'b0, 32'h01020304, '0, 1'b0, 16'd500,
                              16'd499, 1'b1, '0, '0));
    // entry 0: single address 0, single port 65535, high ends are junk
    send_request(fill_request(frmt_pkg::ACT_ADD, 1'b1, 32'h00000000, 32'hFFFFFFFF, 1'b0,
                              16'd65535, 16'd0, 1'b0, '0, '0));
    // entry 1: deny everything
    send_request(fill_request(frmt_pkg::ACT_ADD, 1'b0, 32'h00000000, 32'hFFFFFFFF, 1'b1,
                              16'd1, 16'd65535, 1'b1, '0, '0));
    // entry 2: reversed address range, stored but never matches
    send_request(fill_request(frmt_pkg::ACT_ADD, 1'b1, 32'hFFFF0000, 32'h0000FFFF, 1'b1,
                              16'd1, 16'd65535, 1'b1, '0, '0));
    // entry 3: shadowed by entry 1 until that one goes
    send_request(fill_request(frmt_pkg::ACT_ADD, 1'b1, 32'h80000000, 32'h0, 1'b0, 16'd100,
                              16'd0, 1'b0, '0, '0));
    send_request(fill_request(frmt_pkg::ACT_CHECK, 1'b0, '1, '1, 1'b1, '1, '1, 1'b1, 32'h0,
                              16'd65535));
    send_request(fill_request(frmt_pkg::ACT_CHECK, 1'b0, '0, '0, 1'b0, '0, '0, 1'b0, 32'h0,
                              16'd65534));
    // top address bit set: compare must be on full 32-bit values
    send_request(fill_request(frmt_pkg::ACT_CHECK, 1'b0, '0, '0, 1'b0, '0, '0, 1'b0,
                              32'h80000000, 16'd100));
    // same check again gives the same answer
    send_request(fill_request(frmt_pkg::ACT_CHECK, 1'b0, '0, '0, 1'b0, '0, '0, 1'b0,
                              32'h80000000, 16'd100));
    // delete entry 1 with the opposite allow mark; later entries move up
    send_request(fill_request(frmt_pkg::ACT_DELETE, 1'b1, 32'h00000000, 32'hFFFFFFFF, 1'b1,
                              16'd1, 16'd65535, 1'b1, '0, '0));
    send_request(fill_request(frmt_pkg::ACT_CHECK, 1'b0, '0, '0, 1'b0, '0, '0, 1'b0,
                              32'h80000000, 16'd100));
    send_request(fill_request(frmt_pkg::ACT_CHECK, 1'b0, '0, '0, 1'b0, '0, '0, 1'b0,
                              32'hFFFF8000, 16'd5));
    // the same delete again finds nothing, as does one with a zero port
    send_request(fill_request(frmt_pkg::ACT_DELETE, 1'b0, 32'h00000000, 32'hFFFFFFFF, 1'b1,
                              16'd1, 16'd65535, 1'b1, '0, '0));
    send_request(fill_request(frmt_pkg::ACT_DELETE, 1'b0, 32'h00000000, '0, 1'b0, 16'd0,
                              16'd0, 1'b0, '0, '0));
    // delete of a single-value rule with junk high ends
    send_request(fill_request(frmt_pkg::ACT_DELETE, 1'b0, 32'h00000000, 32'h12345678, 1'b0,
                              16'd65535, 16'd7, 1'b0, '0, '0));
    // range flag differs from the stored one: not found
    send_request(fill_request(frmt_pkg::ACT_DELETE, 1'b1, 32'h80000000, 32'h0, 1'b0, 16'd100,
                              16'd100, 1'b1, '0, '0));
    send_request(fill_request(frmt_pkg::ACT_CHECK, 1'b0, '0, '0, 1'b0, '0, '0, 1'b0,
                              32'h80000000, 16'd100));

    // --- random traffic in four idle/stall patterns ---
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
          add_pct       = 45;
          delete_pct    = 15;
          // long receiver hold-off while requests keep coming: fills the block
          holdoff_seq  <= holdoff_seq + 1;
        end
        1: begin
          send_idle_pct = 45;
          stall_pct     = 0;
          add_pct       = 30;
          delete_pct    = 30;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 45;
          add_pct       = 25;
          delete_pct    = 40;
        end
        default: begin
          send_idle_pct = 10;
          stall_pct     = 10;
          add_pct       = 40;
          delete_pct    = 20;
        end
      endcase
      for (k = 0; k < RANDOM_PER_PHASE; k++) begin
        send_request(random_request());
        if (k == RANDOM_PER_PHASE / 2) drain_results();
      end
    end

    // --- wind down ---
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("** firewall_rule_match_table: PASSED **");
    end else begin
      if (pending != 0) $display("%0d requests never answered", pending);
      $display("** firewall_rule_match_table: FAILED **");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/frmt_pkg.sv
rtl/core/frmt_cell.sv
rtl/core/firewall_rule_match_table.sv
bench/rule_table_checker.sv
bench/testbench.sv
